// ===== design/sst_pkg.sv =====
package sst_pkg;

   // default store depth and fixed field widths
   localparam int SET_CAPACITY_DEF = 64;
   localparam int VALUE_W          = 32;
   localparam int INDEX_W          = 6;
   localparam int COUNT_OUT_W      = 7;
   localparam int REQ_DATA_W       = 40;
   localparam int RSP_DATA_W       = 48;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_LOOKUP = 2'd2,
      MODE_READ   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_DONE     = 2'd0,
      STAT_NOCHANGE = 2'd1,
      STAT_FULL     = 2'd2,
      STAT_RANGE    = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_APPLY = 1'b1
   } state_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                       eval;
      logic                       do_ins;
      logic                       do_rem;
      logic signed [VALUE_W-1:0]  eval_value;
      logic signed [VALUE_W-1:0]  hold_value;
      logic [INDEX_W-1:0]         index;
   } cell_ctl_type;

endpackage

// ===== design/sst_cell.sv =====
module sst_cell import sst_pkg::*; #(
   parameter int POS   = 0,
   parameter int CNT_W = 7
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cell_ctl_type              ctl,
   input  logic [CNT_W-1:0]          count,
   input  logic                      lo_ins,
   input  logic [VALUE_W-1:0]        lo_data,
   input  logic [VALUE_W-1:0]        hi_data,
   output logic [VALUE_W-1:0]        data,
   output logic                      ins,
   output logic                      eq,
   output logic [VALUE_W-1:0]        rd_data
);

   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam logic [CNT_W-1:0] POS_C   = CNT_W'(POS);
   localparam logic [CMP_W-1:0] POS_IDX = CMP_W'(POS);

   logic [VALUE_W-1:0] data_ff, data_in;
   logic               eq_ff, eq_in;
   logic               gt_ff, gt_in;
   logic               sel_ff, sel_in;
   logic               occ;

   // compare against the broadcast operand
   always_comb begin
      occ    = POS_C < count;
      eq_in  = occ && (data_ff == ctl.eval_value);
      gt_in  = occ && ($signed(data_ff) > ctl.eval_value);
      sel_in = occ && (CMP_W'(ctl.index) == POS_IDX);
   end

   // this cell opens or shifts up on insert
   assign ins = gt_ff || (POS_C == count);

   // new entry from the neighbours
   always_comb begin
      data_in = data_ff;
      if (ctl.do_ins && ins) begin
         data_in = lo_ins ? lo_data : ctl.hold_value;
      end else if (ctl.do_rem && (eq_ff || gt_ff)) begin
         data_in = hi_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eq_ff  <= 1'b0;
         gt_ff  <= 1'b0;
         sel_ff <= 1'b0;
      end else if (ctl.eval) begin
         eq_ff  <= eq_in;
         gt_ff  <= gt_in;
         sel_ff <= sel_in;
      end
   end

   assign data    = data_ff;
   assign eq      = eq_ff;
   assign rd_data = sel_ff ? data_ff : '0;

endmodule

// ===== design/sorted_set_table.sv =====
// Sorted set table: holds up to SET_CAPACITY distinct signed 32-bit values in
// ascending order in a row of cells, one entry per cell. Each request transfer
// carries an insert, remove, lookup or read-at-index operation and produces
// exactly one response transfer. Each item has an accept and a shift cycle: in
// the accept cycle every cell compares its entry with the operand in parallel
// and registers the result; in the shift cycle cells shift up or down by one place
// towards their neighbours and the response register is loaded. The shift cycle
// waits while the response register holds an untaken result, and req_tready
// is low until it completes. Insert into a full table is rejected with status
// 2; a read at or beyond the current count returns status 3 and zero data.
module sorted_set_table import sst_pkg::*; #(
   parameter int SET_CAPACITY = SET_CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // mode [1:0], value [33:2], index [39:34]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // found [0], status [2:1], count [9:3], entry_value [41:10], zero fill above
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int CNT_W = $clog2(SET_CAPACITY + 1);
   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam logic [CNT_W-1:0] CAP_C = CNT_W'(SET_CAPACITY);

   state_type state_ff, state_in;

   logic [CNT_W-1:0]         count_ff, count_in;
   mode_type                 mode_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [INDEX_W-1:0]       index_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                     req_xfer, rsp_xfer, out_free, commit;
   cell_ctl_type             ctl;

   logic [VALUE_W-1:0] cell_data [SET_CAPACITY];
   logic [VALUE_W-1:0] cell_rd   [SET_CAPACITY];
   logic               cell_ins  [SET_CAPACITY];
   logic               cell_eq   [SET_CAPACITY];

   logic               found;
   logic [VALUE_W-1:0] rd_or;
   logic               full;
   logic               do_ins, do_rem;
   logic               r_found;
   status_type         r_status;
   logic [VALUE_W-1:0] r_entry;

   // handshakes
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_valid_ff && rsp_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == ST_APPLY) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_xfer) state_in = ST_APPLY;
         ST_APPLY: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // hold the operation for the shift cycle
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         mode_ff  <= mode_type'(req_tdata[1:0]);
         value_ff <= $signed(req_tdata[33:2]);
         index_ff <= req_tdata[39:34];
      end
   end

   // reduce the cell flags
   always_comb begin
      found = 1'b0;
      rd_or = '0;
      for (int i = 0; i < SET_CAPACITY; i++) begin
         found = found | cell_eq[i];
         rd_or = rd_or | cell_rd[i];
      end
   end

   // result and shift decisions
   always_comb begin
      full     = (count_ff == CAP_C);
      do_ins   = 1'b0;
      do_rem   = 1'b0;
      r_found  = found;
      r_status = STAT_DONE;
      r_entry  = '0;
      count_in = count_ff;
      unique case (mode_ff)
         MODE_INSERT: begin
            if (found) begin
               r_status = STAT_NOCHANGE;
            end else if (full) begin
               r_status = STAT_FULL;
            end else begin
               do_ins   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         MODE_REMOVE: begin
            if (found) begin
               do_rem   = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end else begin
               r_status = STAT_NOCHANGE;
            end
         end
         MODE_LOOKUP: begin
            r_status = STAT_DONE;
         end
         MODE_READ: begin
            r_found = 1'b0;
            if (CMP_W'(index_ff) >= CMP_W'(count_ff)) begin
               r_status = STAT_RANGE;
            end else begin
               r_entry = rd_or;
            end
         end
         default: r_status = STAT_DONE;
      endcase
   end

   // broadcast to the cells
   always_comb begin
      ctl.eval       = req_xfer;
      ctl.do_ins     = commit && do_ins;
      ctl.do_rem     = commit && do_rem;
      ctl.eval_value = $signed(req_tdata[33:2]);
      ctl.hold_value = value_ff;
      ctl.index      = req_tdata[39:34];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (commit) begin
         count_ff <= count_in;
      end
   end

   // row of cells
   for (genvar g = 0; g < SET_CAPACITY; g++) begin : g_cell
      logic               lo_ins;
      logic [VALUE_W-1:0] lo_data;
      logic [VALUE_W-1:0] hi_data;

      if (g == 0) begin : g_first
         assign lo_ins  = 1'b0;
         assign lo_data = '0;
      end else begin : g_mid_lo
         assign lo_ins  = cell_ins[g-1];
         assign lo_data = cell_data[g-1];
      end

      if (g == SET_CAPACITY - 1) begin : g_last
         assign hi_data = cell_data[g];
      end else begin : g_mid_hi
         assign hi_data = cell_data[g+1];
      end

      sst_cell #(
         .POS   (g),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .count   (count_ff),
         .lo_ins  (lo_ins),
         .lo_data (lo_data),
         .hi_data (hi_data),
         .data    (cell_data[g]),
         .ins     (cell_ins[g]),
         .eq      (cell_eq[g]),
         .rd_data (cell_rd[g])
      );
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, r_entry, COUNT_OUT_W'(count_in), r_status, r_found};
      end else if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== design/sst_checker.sv =====
module sst_checker import sst_pkg::*; #(
   parameter int SET_CAPACITY = SET_CAPACITY_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a pending response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped before transfer");

   // a stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response payload changed while stalled");

   // one item in flight: no back-to-back request transfers
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken during shift cycle");

   // out-of-range read returns zero data
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:1] == STAT_RANGE) |-> (rsp_tdata[41:10] == '0))
      else $error("range status with non-zero entry");

   // count never goes beyond the capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (SET_CAPACITY > 127) || (int'(rsp_tdata[9:3]) <= SET_CAPACITY))
      else $error("count beyond capacity");

endmodule

bind sorted_set_table sst_checker #(
   .SET_CAPACITY (SET_CAPACITY)
) u_sst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
